// ===== rtl/core/bbde_pkg.sv =====
// Shared types, constants and helpers for the base-b digit expansion unit.
// Used by bbde_ctrl, bbde_dp and base_b_digit_expansion_unit; depends on nothing.
`default_nettype none

package bbde_pkg;

    localparam int NUMBER_BITS_DEF = 31;
    localparam int MAX_DIGITS_DEF  = 31;

    localparam int BASE_W  = 5;
    localparam int CHAR_W  = 7;
    localparam int COUNT_W = 5;
    localparam int DIGIT_W = 4;

    // bits of the dividend consumed per long-division cycle
    localparam int CHUNK_BITS = 8;

    localparam logic [BASE_W-1:0]  BASE_TWO   = 5'd2;
    localparam logic [BASE_W-1:0]  BASE_FOUR  = 5'd4;
    localparam logic [BASE_W-1:0]  BASE_EIGHT = 5'd8;
    localparam logic [BASE_W-1:0]  BASE_NINE  = 5'd9;
    localparam logic [BASE_W-1:0]  BASE_HEX   = 5'd16;
    localparam logic [DIGIT_W-1:0] DEC_TEN    = 4'd10;
    localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0]  CHAR_A     = 7'h41;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ERR,
        S_POW,
        S_DIV,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic pow_step;
        logic div_step;
        logic emit;
        logic err;
    } t_cmd;

    typedef struct packed {
        logic base_ok;
        logic base_pow2;
        logic pow_done;
        logic div_done;
        logic emit_done;
    } t_sts;

    function automatic logic [CHAR_W-1:0] to_ascii(input logic [DIGIT_W-1:0] d,
                                                   input logic hex);
        logic [CHAR_W-1:0] c;
        if (hex && (d >= DEC_TEN)) begin
            c = CHAR_A + CHAR_W'(d - DEC_TEN);
        end else begin
            c = CHAR_ZERO + CHAR_W'(d);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/bbde_ctrl.sv =====
// Sequencer for digit expansion: load, divide or shift per digit, then emit, or error.
// Depends on bbde_pkg; drives the command struct into bbde_dp.
`default_nettype none

module bbde_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           start,
    input  wire bbde_pkg::t_sts i_sts,
    output bbde_pkg::t_cmd      o_cmd,
    output logic                busy
);
    import bbde_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    if (!i_sts.base_ok) begin
                        n_state = S_ERR;
                    end else if (i_sts.base_pow2) begin
                        n_state = S_POW;
                    end else begin
                        n_state = S_DIV;
                    end
                end
            end
            S_ERR: begin
                o_cmd.err = 1'b1;
                n_state   = S_IDLE;
            end
            S_POW: begin
                o_cmd.pow_step = 1'b1;
                if (i_sts.pow_done) begin
                    n_state = S_EMIT;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                o_cmd.emit = 1'b1;
                if (i_sts.emit_done) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy = (r_state != S_IDLE);

endmodule

`default_nettype wire

// ===== rtl/core/bbde_dp.sv =====
// Datapath: dividend register, 8-bit-per-cycle long division, shift path for
// power-of-two bases, digit store and registered result outputs. Uses bbde_pkg.
`default_nettype none

module bbde_dp #(
    parameter int NUMBER_BITS = bbde_pkg::NUMBER_BITS_DEF,
    parameter int MAX_DIGITS  = bbde_pkg::MAX_DIGITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire bbde_pkg::t_cmd                 i_cmd,
    output bbde_pkg::t_sts                      o_sts,
    input  wire logic [NUMBER_BITS-1:0]         i_number,
    input  wire logic [bbde_pkg::BASE_W-1:0]    i_base,
    output logic                                o_strobe,
    output logic [bbde_pkg::CHAR_W-1:0]         o_digit_char,
    output logic [bbde_pkg::COUNT_W-1:0]        o_digit_count,
    output logic                                o_last_digit,
    output logic                                o_base_error
);
    import bbde_pkg::*;

    localparam int CHUNKS = (NUMBER_BITS + CHUNK_BITS - 1) / CHUNK_BITS;
    localparam int PW     = CHUNKS * CHUNK_BITS;
    localparam int CKW    = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
    localparam int AW     = $clog2(MAX_DIGITS);
    localparam int CW     = $clog2(MAX_DIGITS + 1);

    logic [PW-1:0]            r_work;
    logic [DIGIT_W-1:0]       r_radix;
    logic                     r_hex;
    logic [2:0]               r_shift;
    logic [DIGIT_W:0]         r_rem;
    logic [CKW-1:0]           r_chunk;
    logic [CW-1:0]            r_count;
    logic [AW-1:0]            r_idx;
    logic [DIGIT_W-1:0]       r_store [MAX_DIGITS];
    logic                     r_strobe;
    logic [CHAR_W-1:0]        r_char;
    logic [COUNT_W-1:0]       r_dcount;
    logic                     r_last;
    logic                     r_err;

    logic [PW-1:0]            w_div_work;
    logic [DIGIT_W:0]         w_div_rem;
    logic [PW-1:0]            w_pow_work;
    logic [DIGIT_W-1:0]       w_pow_digit;
    logic                     w_chunk_last;
    logic                     w_store_en;
    logic [DIGIT_W-1:0]       w_store_digit;
    logic [2:0]               w_in_shift;

    // one chunk of restoring division, MSB first
    always_comb begin
        logic [DIGIT_W:0]      v_rem;
        logic [CHUNK_BITS-1:0] v_q;
        v_rem = r_rem;
        v_q   = '0;
        for (int j = 0; j < CHUNK_BITS; j++) begin
            v_rem = {v_rem[DIGIT_W-1:0], r_work[PW-1-j]};
            if (v_rem >= {1'b0, r_radix}) begin
                v_rem              = v_rem - {1'b0, r_radix};
                v_q[CHUNK_BITS-1-j] = 1'b1;
            end
        end
        w_div_rem  = v_rem;
        w_div_work = (r_work << CHUNK_BITS) | PW'(v_q);
    end

    assign w_pow_work   = r_work >> r_shift;
    assign w_pow_digit  = r_work[DIGIT_W-1:0] & DIGIT_W'((5'd1 << r_shift) - 5'd1);
    assign w_chunk_last = (r_chunk == CKW'(CHUNKS - 1));

    assign w_store_en    = i_cmd.pow_step || (i_cmd.div_step && w_chunk_last);
    assign w_store_digit = i_cmd.pow_step ? w_pow_digit : w_div_rem[DIGIT_W-1:0];

    always_comb begin
        case (i_base)
            BASE_TWO:   w_in_shift = 3'd1;
            BASE_FOUR:  w_in_shift = 3'd2;
            BASE_EIGHT: w_in_shift = 3'd3;
            default:    w_in_shift = 3'd4;
        endcase
    end

    assign o_sts.base_ok   = (i_base inside {[BASE_TWO:BASE_NINE], BASE_HEX});
    assign o_sts.base_pow2 = (i_base inside {BASE_TWO, BASE_FOUR, BASE_EIGHT, BASE_HEX});
    assign o_sts.pow_done  = (w_pow_work == '0);
    assign o_sts.div_done  = w_chunk_last && (w_div_work == '0);
    assign o_sts.emit_done = (r_idx == '0);

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chunk  <= '0;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.emit || i_cmd.err;
            if (i_cmd.load) begin
                r_chunk <= '0;
                r_count <= '0;
            end else begin
                if (i_cmd.div_step) begin
                    r_chunk <= w_chunk_last ? '0 : r_chunk + CKW'(1);
                end
                // saturate: drop digits beyond the store depth
                if (w_store_en && (r_count < CW'(MAX_DIGITS))) begin
                    r_count <= r_count + CW'(1);
                end
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_work  <= PW'(i_number);
            r_radix <= i_base[DIGIT_W-1:0];
            r_hex   <= (i_base == BASE_HEX);
            r_shift <= w_in_shift;
            r_rem   <= '0;
        end else if (i_cmd.pow_step) begin
            r_work <= w_pow_work;
        end else if (i_cmd.div_step) begin
            r_work <= w_div_work;
            r_rem  <= w_chunk_last ? '0 : w_div_rem;
        end

        if (w_store_en && (r_count < CW'(MAX_DIGITS))) begin
            r_store[r_count[AW-1:0]] <= w_store_digit;
            r_idx                    <= r_count[AW-1:0];
        end else if (i_cmd.emit) begin
            r_idx <= r_idx - AW'(1);
        end

        if (i_cmd.err) begin
            r_char   <= '0;
            r_dcount <= '0;
            r_last   <= 1'b1;
            r_err    <= 1'b1;
        end else if (i_cmd.emit) begin
            r_char   <= to_ascii(r_store[r_idx], r_hex);
            r_dcount <= COUNT_W'(r_count);
            r_last   <= (r_idx == '0);
            r_err    <= 1'b0;
        end
    end

    assign o_strobe      = r_strobe;
    assign o_digit_char  = r_char;
    assign o_digit_count = r_dcount;
    assign o_last_digit  = r_last;
    assign o_base_error  = r_err;

endmodule

`default_nettype wire

// ===== rtl/core/base_b_digit_expansion_unit.sv =====
// Top level of the base-b digit expansion unit: joins bbde_ctrl and bbde_dp.
// Depends on bbde_pkg, bbde_ctrl and bbde_dp.
//
// Converts an unsigned number to ASCII digits in base 2..9 or 16, most
// significant digit first, one result per o_strobe pulse; results cannot be
// stalled, so the receiver must take every strobe. A transaction is taken when
// start is high and busy is low, and busy stays high until the last result has
// been issued. Each transaction runs a load, then one shift per digit for bases
// 2, 4, 8 and 16, or chunked long division per digit for bases 3, 5, 6, 7 and 9
// (the long-division step retires 8 dividend bits per cycle), then the emit
// phase, one digit per emit step. An unsupported base gives a single error result.
`default_nettype none

module base_b_digit_expansion_unit #(
    parameter int NUMBER_BITS = bbde_pkg::NUMBER_BITS_DEF,
    parameter int MAX_DIGITS  = bbde_pkg::MAX_DIGITS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [NUMBER_BITS-1:0]      i_number,
    input  wire logic [bbde_pkg::BASE_W-1:0] i_base,
    output logic                             o_strobe,
    output logic [bbde_pkg::CHAR_W-1:0]      o_digit_char,
    output logic [bbde_pkg::COUNT_W-1:0]     o_digit_count,
    output logic                             o_last_digit,
    output logic                             o_base_error
);
    import bbde_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    bbde_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .busy    (busy)
    );

    bbde_dp #(
        .NUMBER_BITS (NUMBER_BITS),
        .MAX_DIGITS  (MAX_DIGITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_number      (i_number),
        .i_base        (i_base),
        .o_strobe      (o_strobe),
        .o_digit_char  (o_digit_char),
        .o_digit_count (o_digit_count),
        .o_last_digit  (o_last_digit),
        .o_base_error  (o_base_error)
    );

endmodule

`default_nettype wire
